@@ rtl/rade_pkg.sv @@
// package for the residue alphabet detect/encode block
// holds command codes, payload structs and the fixed alphabet lookup functions
// no dependencies
package rade_pkg;

	typedef enum logic [1:0] {
		FUNC_SCAN      = 2'd0,
		FUNC_CLASSIFY  = 2'd1,
		FUNC_TRANSLATE = 2'd2,
		FUNC_CLEAR     = 2'd3
	} rade_func_t;

	typedef enum logic {
		ALPHA_NUC  = 1'b0,
		ALPHA_PROT = 1'b1
	} rade_alpha_t;

	localparam int unsigned CntW = 9;
	localparam int unsigned CodeW = 5;
	// mismatch counts of the empty set
	localparam logic [CntW-1:0] NucSetSize = 9'd10;
	localparam logic [CntW-1:0] ProtSetSize = 9'd20;

	typedef struct packed {
		rade_func_t  func;
		logic [7:0]  residue;
		logic [1:0]  random_fill;
	} rade_cmd_t;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic             bad_letter;
		logic             alphabet;
		logic [CntW-1:0]  dna_mismatches;
		logic [CntW-1:0]  protein_mismatches;
	} rade_rsp_t;

	// tracker control and status
	typedef struct packed {
		logic       scan;
		logic       clear;
		logic [7:0] residue;
	} rade_trk_ctl_t;

	typedef struct packed {
		logic [CntW-1:0] dna;
		logic [CntW-1:0] prot;
	} rade_trk_cnt_t;

	typedef struct packed {
		logic             hit;
		logic [CodeW-1:0] idx;
	} rade_lookup_t;

	function automatic logic is_nuc(input logic [7:0] b);
		logic r;
		unique case (b)
			"a", "c", "g", "t", "A", "C", "G", "T", "n", "N": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic rade_lookup_t aa_lookup(input logic [7:0] b);
		rade_lookup_t r;
		r.hit = 1'b1;
		unique case (b)
			"A": r.idx = 5'd0;
			"C": r.idx = 5'd1;
			"D": r.idx = 5'd2;
			"E": r.idx = 5'd3;
			"F": r.idx = 5'd4;
			"G": r.idx = 5'd5;
			"H": r.idx = 5'd6;
			"I": r.idx = 5'd7;
			"K": r.idx = 5'd8;
			"L": r.idx = 5'd9;
			"M": r.idx = 5'd10;
			"N": r.idx = 5'd11;
			"P": r.idx = 5'd12;
			"Q": r.idx = 5'd13;
			"R": r.idx = 5'd14;
			"S": r.idx = 5'd15;
			"T": r.idx = 5'd16;
			"V": r.idx = 5'd17;
			"W": r.idx = 5'd18;
			"Y": r.idx = 5'd19;
			default: begin
				r.hit = 1'b0;
				r.idx = '0;
			end
		endcase
		return r;
	endfunction

	function automatic rade_lookup_t nuc_lookup(input logic [7:0] b, input logic [1:0] fill);
		rade_lookup_t r;
		r.hit = 1'b1;
		unique case (b)
			"A", "a": r.idx = 5'd0;
			"C", "c": r.idx = 5'd1;
			"G", "g": r.idx = 5'd2;
			"T", "t": r.idx = 5'd3;
			"N", "n": r.idx = {3'b000, fill};
			default: begin
				r.hit = 1'b0;
				r.idx = '0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/rade_cmd_if.sv @@
// command channel: valid/ready with the input item payload
// depends on rade_pkg
interface rade_cmd_if
	import rade_pkg::*;
();
	logic       valid;
	logic       ready;
	rade_func_t func;
	logic [7:0] residue;
	logic [1:0] random_fill;

	modport source (output valid, func, residue, random_fill, input ready);
	modport sink (input valid, func, residue, random_fill, output ready);
endinterface

@@ rtl/rade_rsp_if.sv @@
// result channel: valid/ready with the result item payload
// depends on rade_pkg
interface rade_rsp_if
	import rade_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CodeW-1:0] code;
	logic             bad_letter;
	logic             alphabet;
	logic [CntW-1:0]  dna_mismatches;
	logic [CntW-1:0]  protein_mismatches;

	modport source (output valid, code, bad_letter, alphabet, dna_mismatches,
		protein_mismatches, input ready);
	modport sink (input valid, code, bad_letter, alphabet, dna_mismatches,
		protein_mismatches, output ready);
endinterface

@@ rtl/rade_seen_tracker.sv @@
// seen-set of byte values with running mismatch counts against both alphabets
// depends on rade_pkg
module rade_seen_tracker
	import rade_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  rade_trk_ctl_t ctl,
	output rade_trk_cnt_t cnt
);

	logic [255:0]    seen_q;
	logic [CntW-1:0] dna_q;
	logic [CntW-1:0] prot_q;
	logic            newly_seen;
	logic            hit_nuc;
	logic            hit_prot;
	rade_lookup_t    aa;

	assign aa         = aa_lookup(ctl.residue);
	assign hit_nuc    = is_nuc(ctl.residue);
	assign hit_prot   = aa.hit;
	assign newly_seen = ctl.scan && !seen_q[ctl.residue];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			dna_q  <= NucSetSize;
			prot_q <= ProtSetSize;
		end else if (ctl.clear) begin
			seen_q <= '0;
			dna_q  <= NucSetSize;
			prot_q <= ProtSetSize;
		end else if (newly_seen) begin
			seen_q[ctl.residue] <= 1'b1;
			// a member now agrees, a non-member now disagrees
			dna_q  <= hit_nuc ? dna_q - 1'b1 : dna_q + 1'b1;
			prot_q <= hit_prot ? prot_q - 1'b1 : prot_q + 1'b1;
		end
	end

	assign cnt.dna  = dna_q;
	assign cnt.prot = prot_q;

`ifndef SYNTHESIS
	a_clear_restores: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (dna_q == NucSetSize) && (prot_q == ProtSetSize))
		else $error("counts not restored after clear");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dna_q <= 9'd256) && (prot_q <= 9'd256))
		else $error("mismatch count out of range");
	a_rescan_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan && !ctl.clear && seen_q[ctl.residue])
		|=> $stable(dna_q) && $stable(prot_q))
		else $error("rescan of a seen byte changed counts");
	a_scan_sets_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan && !ctl.clear) |=> seen_q[$past(ctl.residue)])
		else $error("scanned byte not marked");
`endif

endmodule

@@ rtl/residue_alphabet_detect_encode.sv @@
// residue alphabet detect/encode: two-stage pipeline, input register then result register
// flow: an accepted command waits in the input register, then its result is registered
// throughput: one item per cycle; the input stalls only while a result waits on rsp.ready
// reset: seen set empty, counts at 10 and 20, stored alphabet nucleotide, no item held
// depends on rade_pkg, rade_cmd_if, rade_rsp_if, rade_seen_tracker
module residue_alphabet_detect_encode
	import rade_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rade_cmd_if.sink    cmd,
	rade_rsp_if.source  rsp
);

	rade_cmd_t     cmd_s1;
	logic          valid_s1;
	rade_rsp_t     rsp_s2;
	logic          valid_s2;
	rade_alpha_t   alpha_q;
	rade_trk_ctl_t trk_ctl;
	rade_trk_cnt_t trk_cnt;
	rade_rsp_t     rsp_d;
	rade_lookup_t  nuc_hit;
	rade_lookup_t  aa_hit;
	rade_lookup_t  sel_hit;
	logic          needs_out;
	logic          out_free;
	logic          fire_s1;
	logic          choose_prot;

	assign out_free = !valid_s2 || rsp.ready;
	assign fire_s1  = valid_s1 && (!needs_out || out_free);
	assign cmd.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else if (cmd.ready && cmd.valid) begin
			cmd_s1.func        <= cmd.func;
			cmd_s1.residue     <= cmd.residue;
			cmd_s1.random_fill <= cmd.random_fill;
		end
	end

	assign trk_ctl.scan    = fire_s1 && (cmd_s1.func == FUNC_SCAN);
	assign trk_ctl.clear   = fire_s1 && (cmd_s1.func == FUNC_CLEAR);
	assign trk_ctl.residue = cmd_s1.residue;

	rade_seen_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (trk_ctl),
		.cnt    (trk_cnt)
	);

	assign nuc_hit     = nuc_lookup(cmd_s1.residue, cmd_s1.random_fill);
	assign aa_hit      = aa_lookup(cmd_s1.residue);
	assign sel_hit     = (alpha_q == ALPHA_PROT) ? aa_hit : nuc_hit;
	assign choose_prot = trk_cnt.prot < trk_cnt.dna;

	always_comb begin
		rsp_d     = '0;
		needs_out = 1'b0;
		unique case (cmd_s1.func)
			FUNC_CLASSIFY: begin
				needs_out                = 1'b1;
				rsp_d.alphabet           = choose_prot;
				rsp_d.dna_mismatches     = trk_cnt.dna;
				rsp_d.protein_mismatches = trk_cnt.prot;
			end
			FUNC_TRANSLATE: begin
				needs_out        = 1'b1;
				rsp_d.code       = sel_hit.hit ? sel_hit.idx : '0;
				rsp_d.bad_letter = !sel_hit.hit;
				rsp_d.alphabet   = alpha_q;
			end
			FUNC_SCAN, FUNC_CLEAR: begin
				needs_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_NUC;
		end else if (fire_s1 && (cmd_s1.func == FUNC_CLASSIFY)) begin
			alpha_q <= choose_prot ? ALPHA_PROT : ALPHA_NUC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && needs_out) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && needs_out) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid              = valid_s2;
	assign rsp.code               = rsp_s2.code;
	assign rsp.bad_letter         = rsp_s2.bad_letter;
	assign rsp.alphabet           = rsp_s2.alphabet;
	assign rsp.dna_mismatches     = rsp_s2.dna_mismatches;
	assign rsp.protein_mismatches = rsp_s2.protein_mismatches;

`ifndef SYNTHESIS
	a_stalled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp.ready) |=> valid_s2 && $stable(rsp_s2))
		else $error("held result changed under stall");
	a_bad_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_s2.bad_letter) |-> (rsp_s2.code == '0))
		else $error("bad letter with nonzero code");
	a_nuc_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (rsp_s2.alphabet == ALPHA_NUC) && (rsp_s2.dna_mismatches == '0)
		&& (rsp_s2.protein_mismatches == '0)) |-> (rsp_s2.code <= 5'd3))
		else $error("nucleotide code out of range");
`endif

endmodule

@@ test/rade_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// scoreboard for the residue alphabet detect/encode block: predicts each result
// from the accepted commands and checks the results in order; depends on rade_pkg
package rade_scoreboard_pkg;
	import rade_pkg::*;

	localparam string NucLetters = "acgtACGTnN";
	localparam string ProtLetters = "ACDEFGHIKLMNPQRSTVWY";

	class alphabet_scoreboard;
		bit [255:0]   seen;
		rade_alpha_t  chosen;
		rade_rsp_t    pending[$];
		int unsigned  errors;

		function new();
			seen = '0;
			chosen = ALPHA_NUC;
			errors = 0;
		endfunction

		static function int letter_pos(string letters, logic [7:0] b);
			logic [7:0] ch;
			for (int i = 0; i < letters.len(); i++) begin
				ch = letters[i];
				if (ch == b)
					return i;
			end
			return -1;
		endfunction

		function int unsigned pending_count();
			return pending.size();
		endfunction

		// updates the seen set and stored alphabet, queues the result if any
		function void note_command(rade_cmd_t c);
			rade_rsp_t   r;
			int          pos;
			int unsigned dna;
			int unsigned prot;
			r = '0;
			dna = 0;
			prot = 0;
			case (c.func)
				FUNC_SCAN: seen[c.residue] = 1'b1;
				FUNC_CLEAR: seen = '0;
				FUNC_CLASSIFY: begin
					for (int b = 0; b < 256; b++) begin
						if (seen[b] != (letter_pos(NucLetters, 8'(b)) >= 0))
							dna++;
						if (seen[b] != (letter_pos(ProtLetters, 8'(b)) >= 0))
							prot++;
					end
					// ties go to nucleotide
					chosen = (prot < dna) ? ALPHA_PROT : ALPHA_NUC;
					r.alphabet = chosen;
					r.dna_mismatches = CntW'(dna);
					r.protein_mismatches = CntW'(prot);
					pending.push_back(r);
				end
				default: begin
					if (chosen == ALPHA_PROT) begin
						pos = letter_pos(ProtLetters, c.residue);
					end else begin
						// letter order is acgt ACGT nN, so the first eight fold to 0-3
						pos = letter_pos(NucLetters, c.residue);
						if (pos >= 8)
							pos = c.random_fill;
						else if (pos >= 0)
							pos = pos % 4;
					end
					if (pos < 0)
						r.bad_letter = 1'b1;
					else
						r.code = CodeW'(pos);
					r.alphabet = chosen;
					pending.push_back(r);
				end
			endcase
		endfunction

		function void check_result(rade_rsp_t got);
			rade_rsp_t want;
			if (pending.size() == 0) begin
				$error("result with no command waiting: code %0d alphabet %0d",
					got.code, got.alphabet);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.code !== want.code) begin
				$error("code: expected %0d, actual %0d", want.code, got.code);
				errors++;
			end
			if (got.bad_letter !== want.bad_letter) begin
				$error("bad_letter: expected %0d, actual %0d", want.bad_letter, got.bad_letter);
				errors++;
			end
			if (got.alphabet !== want.alphabet) begin
				$error("alphabet: expected %0d, actual %0d", want.alphabet, got.alphabet);
				errors++;
			end
			if (got.dna_mismatches !== want.dna_mismatches) begin
				$error("dna_mismatches: expected %0d, actual %0d",
					want.dna_mismatches, got.dna_mismatches);
				errors++;
			end
			if (got.protein_mismatches !== want.protein_mismatches) begin
				$error("protein_mismatches: expected %0d, actual %0d",
					want.protein_mismatches, got.protein_mismatches);
				errors++;
			end
		endfunction
	endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// top-level testbench for residue_alphabet_detect_encode: directed and random
// command streams with bursty sender and stalling receiver; depends on rade_pkg,
// rade_cmd_if, rade_rsp_if and rade_scoreboard_pkg
module tb_top;
	import rade_pkg::*;
	import rade_scoreboard_pkg::*;

	typedef enum {BIAS_NUC, BIAS_PROT, BIAS_ANY} byte_bias_t;

	localparam int unsigned RandomItems = 1550;
	localparam int unsigned IdleLimit = 3000;
	localparam int unsigned DrainCycles = 8;

	logic clk;
	logic arst_n;

	rade_cmd_if cmd();
	rade_rsp_if rsp();

	residue_alphabet_detect_encode dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	alphabet_scoreboard board;
	int unsigned burst_left;
	int unsigned items_sent;
	int unsigned idle_cycles;
	rade_cmd_t   seen_cmd;
	rade_rsp_t   seen_rsp;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive one item and hold it until accepted; gaps fall between bursts
	task automatic send(input rade_func_t f, input logic [7:0] b, input logic [1:0] fill);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		cmd.valid <= 1'b1;
		cmd.func <= f;
		cmd.residue <= b;
		cmd.random_fill <= fill;
		do @(posedge clk); while (!cmd.ready);
		burst_left--;
		items_sent++;
	endtask

	function automatic logic [7:0] pick_byte(byte_bias_t bias);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 85) begin
			if (bias == BIAS_NUC)
				b = NucLetters[$urandom_range(0, NucLetters.len() - 1)];
			else if (bias == BIAS_PROT)
				b = ProtLetters[$urandom_range(0, ProtLetters.len() - 1)];
		end
		return b;
	endfunction

	// optionally clear, then scan a biased set, classify, then translate against it
	task automatic run_sequence();
		byte_bias_t bias;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		bias = (pick < 4) ? BIAS_NUC : (pick < 8) ? BIAS_PROT : BIAS_ANY;
		if ($urandom_range(0, 3) != 0)
			send(FUNC_CLEAR, 8'($urandom), 2'($urandom));
		repeat ($urandom_range(1, 16))
			send(FUNC_SCAN, pick_byte(bias), 2'($urandom));
		send(FUNC_CLASSIFY, 8'($urandom), 2'($urandom));
		repeat ($urandom_range(1, 12))
			send(FUNC_TRANSLATE, pick_byte(bias), 2'($urandom));
		// unstructured noise
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4))
				send(rade_func_t'($urandom_range(0, 3)), 8'($urandom), 2'($urandom));
	endtask

	// receiver stalls with a rate that changes segment by segment
	initial begin
		int unsigned seg_len;
		int unsigned stall_pct;
		rsp.ready <= 1'b0;
		forever begin
			seg_len = $urandom_range(1, 60);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (seg_len) begin
				@(posedge clk);
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// monitor: results are checked before the same edge's command is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				seen_rsp.code = rsp.code;
				seen_rsp.bad_letter = rsp.bad_letter;
				seen_rsp.alphabet = rsp.alphabet;
				seen_rsp.dna_mismatches = rsp.dna_mismatches;
				seen_rsp.protein_mismatches = rsp.protein_mismatches;
				board.check_result(seen_rsp);
			end
			if (cmd.valid && cmd.ready) begin
				seen_cmd.func = cmd.func;
				seen_cmd.residue = cmd.residue;
				seen_cmd.random_fill = cmd.random_fill;
				board.note_command(seen_cmd);
			end
			if ((rsp.valid && rsp.ready) || (cmd.valid && cmd.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("residue_alphabet_detect_encode test failed");
				$finish;
			end
		end
	end

	initial begin
		string tie_letters;
		board = new();
		burst_left = 0;
		items_sent = 0;
		idle_cycles = 0;
		tie_letters = "ACGTNDEFHI";
		arst_n = 1'b0;
		cmd.valid <= 1'b0;
		cmd.func <= FUNC_SCAN;
		cmd.residue <= 8'h00;
		cmd.random_fill <= 2'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, reset alphabet, fill values for n/N, a byte outside both sets
		send(FUNC_CLASSIFY, 8'h00, 2'd0);
		send(FUNC_TRANSLATE, "A", 2'd0);
		send(FUNC_TRANSLATE, "n", 2'd3);
		send(FUNC_TRANSLATE, "N", 2'd2);
		send(FUNC_TRANSLATE, 8'hFF, 2'd1);
		send(FUNC_SCAN, 8'h00, 2'd0);
		send(FUNC_SCAN, 8'hFF, 2'd3);
		send(FUNC_CLASSIFY, 8'hFF, 2'd3);
		send(FUNC_CLEAR, 8'h00, 2'd0);
		// five shared letters plus five protein-only ones: equal counts
		foreach (tie_letters[i])
			send(FUNC_SCAN, tie_letters[i], 2'd0);
		send(FUNC_CLASSIFY, 8'h00, 2'd0);
		send(FUNC_CLASSIFY, 8'h00, 2'd0);
		// two more protein letters tip it to protein
		send(FUNC_SCAN, "K", 2'd0);
		send(FUNC_SCAN, "L", 2'd0);
		send(FUNC_CLASSIFY, 8'h00, 2'd0);
		send(FUNC_TRANSLATE, "a", 2'd0);
		send(FUNC_TRANSLATE, "Y", 2'd0);
		// clear keeps the stored alphabet
		send(FUNC_CLEAR, 8'hFF, 2'd3);
		send(FUNC_TRANSLATE, "N", 2'd3);

		items_sent = 0;
		while (items_sent < RandomItems)
			run_sequence();
		cmd.valid <= 1'b0;

		while (board.pending_count() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (board.errors == 0 && board.pending_count() == 0) begin
			$display("residue_alphabet_detect_encode test passed");
		end else begin
			$display("residue_alphabet_detect_encode test failed");
		end
		$finish;
	end

endmodule
